[hw/rtl/quadratic_root_solver_macros.svh]
// Assertion macros shared by the quadratic root solver RTL.
`ifndef QUADRATIC_ROOT_SOLVER_MACROS_SVH
`define QUADRATIC_ROOT_SOLVER_MACROS_SVH
`ifndef ASSERT_OFF
`define QRS_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define QRS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define QRS_ASSERT_IMPL(lbl, clk, rst_n, ante, cons)
`define QRS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

[hw/rtl/qrs_pkg.sv]
// Shared types and constants of the quadratic root solver.
package qrs_pkg;
    localparam int OUT_FRAC = 16;

    typedef enum logic [1:0] {
        ST_TWO  = 2'd0,
        ST_ONE  = 2'd1,
        ST_NONE = 2'd2,
        ST_ZERO = 2'd3
    } t_status;
endpackage

[hw/rtl/qrs_sqrt.sv]
// Pipelined integer square root of a radicand scaled by 2^32, one root bit per stage.
module qrs_sqrt #(
    parameter int IN_W = 33
) (
    input  logic                                          i_clk,
    input  logic                                          i_en,
    input  logic [IN_W-1:0]                               i_rad,
    output logic [(IN_W+2*qrs_pkg::OUT_FRAC+1)/2-1:0]     o_root
);
    localparam int K    = (IN_W + 2 * qrs_pkg::OUT_FRAC + 1) / 2;
    localparam int XW   = 2 * K;
    localparam int REMW = K + 2;

    logic [XW-1:0]   r_x    [K];
    logic [REMW-1:0] r_rem  [K];
    logic [K-1:0]    r_root [K];

    for (genvar j = 0; j < K; j++) begin : g_stage
        logic [XW-1:0]   s_x;
        logic [REMW-1:0] s_rem;
        logic [K-1:0]    s_root;
        logic [REMW+1:0] n_sh;
        logic [REMW+1:0] n_trial;
        logic            n_ge;

        if (j == 0) begin : g_first
            assign s_x    = XW'(i_rad) << (2 * qrs_pkg::OUT_FRAC);
            assign s_rem  = '0;
            assign s_root = '0;
        end else begin : g_next
            assign s_x    = r_x[j-1];
            assign s_rem  = r_rem[j-1];
            assign s_root = r_root[j-1];
        end

        always_comb begin
            n_sh    = {s_rem, s_x[XW-1:XW-2]};
            n_trial = (REMW+2)'({s_root, 2'b01});
            n_ge    = (n_sh >= n_trial);
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_x[j]    <= s_x << 2;
                r_rem[j]  <= n_ge ? REMW'(n_sh - n_trial) : REMW'(n_sh);
                r_root[j] <= {s_root[K-2:0], n_ge};
            end
        end
    end

    assign o_root = r_root[K-1];
endmodule

[hw/rtl/qrs_div.sv]
// Pipelined signed divider with round-half-away rounding and clipping to 32 bits.
module qrs_div #(
    parameter int NUM_W = 50,
    parameter int DEN_W = 18
) (
    input  logic                    i_clk,
    input  logic                    i_en,
    input  logic signed [NUM_W-1:0] i_num,
    input  logic signed [DEN_W-1:0] i_den,
    output logic [31:0]             o_quot,
    output logic                    o_sat
);
    localparam int QW = NUM_W + 1;

    logic [NUM_W-1:0] n_un;
    logic [DEN_W-1:0] n_ud;
    logic [QW-1:0]    r_p_num;
    logic [DEN_W-1:0] r_p_ud;
    logic             r_p_neg;

    always_comb begin
        n_un = i_num[NUM_W-1] ? NUM_W'(-i_num) : NUM_W'(i_num);
        n_ud = i_den[DEN_W-1] ? DEN_W'(-i_den) : DEN_W'(i_den);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p_num <= QW'(n_un) + QW'(n_ud >> 1);
            r_p_ud  <= n_ud;
            r_p_neg <= i_num[NUM_W-1] ^ i_den[DEN_W-1];
        end
    end

    logic [QW-1:0]    r_num [QW];
    logic [QW-1:0]    r_q   [QW];
    logic [DEN_W-1:0] r_rem [QW];
    logic [DEN_W-1:0] r_ud  [QW];
    logic             r_neg [QW];

    for (genvar j = 0; j < QW; j++) begin : g_stage
        logic [QW-1:0]    s_num;
        logic [QW-1:0]    s_q;
        logic [DEN_W-1:0] s_rem;
        logic [DEN_W-1:0] s_ud;
        logic             s_neg;
        logic [DEN_W:0]   n_sh;
        logic             n_ge;

        if (j == 0) begin : g_first
            assign s_num = r_p_num;
            assign s_q   = '0;
            assign s_rem = '0;
            assign s_ud  = r_p_ud;
            assign s_neg = r_p_neg;
        end else begin : g_next
            assign s_num = r_num[j-1];
            assign s_q   = r_q[j-1];
            assign s_rem = r_rem[j-1];
            assign s_ud  = r_ud[j-1];
            assign s_neg = r_neg[j-1];
        end

        always_comb begin
            n_sh = {s_rem, s_num[QW-1]};
            n_ge = (n_sh >= {1'b0, s_ud});
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_num[j] <= s_num << 1;
                r_q[j]   <= {s_q[QW-2:0], n_ge};
                r_rem[j] <= n_ge ? DEN_W'(n_sh - {1'b0, s_ud}) : DEN_W'(n_sh);
                r_ud[j]  <= s_ud;
                r_neg[j] <= s_neg;
            end
        end
    end

    logic [QW-1:0] n_q;
    logic          n_ovf_p;
    logic          n_ovf_n;
    logic [31:0]   n_quot;
    logic          n_sat;
    logic [31:0]   r_quot;
    logic          r_sat;

    always_comb begin
        n_q     = r_q[QW-1];
        n_ovf_p = |n_q[QW-1:31];
        n_ovf_n = (|n_q[QW-1:32]) | (n_q[31] & (|n_q[30:0]));
        if (r_neg[QW-1]) begin
            n_sat  = n_ovf_n;
            n_quot = n_ovf_n ? 32'h8000_0000 : 32'(~n_q[31:0] + 32'd1);
        end else begin
            n_sat  = n_ovf_p;
            n_quot = n_ovf_p ? 32'h7FFF_FFFF : n_q[31:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_quot <= n_quot;
            r_sat  <= n_sat;
        end
    end

    assign o_quot = r_quot;
    assign o_sat  = r_sat;
endmodule

[hw/rtl/quadratic_root_solver.sv]
// Top level of the quadratic root solver: discriminant, square root, four dividers.
// Latency is set by one square-root stage per root bit and one divider stage
// per quotient bit.
// Throughput is one transaction per cycle; the whole pipeline holds when the output
// register is full and not taken.
// Reset is synchronous and active low and clears all valid bits; data is not reset.
`include "quadratic_root_solver_macros.svh"
module quadratic_root_solver #(
    parameter int COEF_WIDTH     = 16,
    parameter int COEF_FRAC_BITS = 8
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_ready,
    input  logic signed [COEF_WIDTH-1:0] i_coef_a,
    input  logic signed [COEF_WIDTH-1:0] i_coef_b,
    input  logic signed [COEF_WIDTH-1:0] i_coef_c,
    output logic                         o_valid,
    input  logic                         i_ready,
    output logic [1:0]                   o_root_status,
    output logic signed [31:0]           o_root_plus,
    output logic signed [31:0]           o_root_minus,
    output logic signed [31:0]           o_vertex_x,
    output logic signed [31:0]           o_vertex_y,
    output logic                         o_saturated
);
    localparam int W       = COEF_WIDTH;
    localparam int DW      = 2 * W + 2;
    localparam int DUW     = 2 * W + 1;
    localparam int NBW     = W + 17;
    localparam int SQ_LAT  = (DUW + 2 * qrs_pkg::OUT_FRAC + 1) / 2;
    localparam int NW      = 2 * W + 18;
    localparam int DENW    = W + 2;
    localparam int DIV_LAT = NW + 3;
    localparam int YSH     = qrs_pkg::OUT_FRAC - COEF_FRAC_BITS;

    logic en;
    assign en      = !o_valid || i_ready;
    assign o_ready = en;

    logic signed [2*W-1:0] n1_bb;
    logic signed [2*W-1:0] n1_ac;
    assign n1_bb = i_coef_b * i_coef_b;
    assign n1_ac = i_coef_a * i_coef_c;

    logic                  r1_vld;
    logic signed [W-1:0]   r1_a;
    logic signed [W-1:0]   r1_b;
    logic signed [2*W-1:0] r1_bb;
    logic signed [2*W-1:0] r1_ac;

    logic signed [DW-1:0]  n2_d;
    logic signed [NBW-1:0] n2_nb;
    qrs_pkg::t_status      n2_status;

    always_comb begin
        n2_d  = DW'(r1_bb) - (DW'(r1_ac) <<< 2);
        n2_nb = (-NBW'(r1_b)) <<< qrs_pkg::OUT_FRAC;
        if (r1_a == '0) begin
            n2_status = qrs_pkg::ST_ZERO;
        end else if (n2_d[DW-1]) begin
            n2_status = qrs_pkg::ST_NONE;
        end else if (n2_d == '0) begin
            n2_status = qrs_pkg::ST_ONE;
        end else begin
            n2_status = qrs_pkg::ST_TWO;
        end
    end

    logic                  r2_vld;
    logic signed [DW-1:0]  r2_d;
    logic signed [NBW-1:0] r2_nb;
    logic signed [W-1:0]   r2_a;
    qrs_pkg::t_status      r2_status;

    logic [DUW-1:0]    sq_rad;
    logic [SQ_LAT-1:0] sq_root;
    assign sq_rad = r2_d[DW-1] ? '0 : r2_d[DUW-1:0];

    qrs_sqrt #(
        .IN_W(DUW)
    ) u_sqrt (
        .i_clk (i_clk),
        .i_en  (en),
        .i_rad (sq_rad),
        .o_root(sq_root)
    );

    logic                  r_sv  [SQ_LAT];
    qrs_pkg::t_status      r_sst [SQ_LAT];
    logic signed [NBW-1:0] r_snb [SQ_LAT];
    logic signed [DW-1:0]  r_sd  [SQ_LAT];
    logic signed [W-1:0]   r_sa  [SQ_LAT];

    logic signed [NW-1:0] n3_s;
    assign n3_s = NW'(sq_root);

    logic                   r3_vld;
    qrs_pkg::t_status       r3_status;
    logic signed [NW-1:0]   r3_nump;
    logic signed [NW-1:0]   r3_numm;
    logic signed [NW-1:0]   r3_numx;
    logic signed [NW-1:0]   r3_numy;
    logic signed [DENW-1:0] r3_den2;
    logic signed [DENW-1:0] r3_den4;

    logic [31:0] rp_q;
    logic [31:0] rm_q;
    logic [31:0] vx_q;
    logic [31:0] vy_q;
    logic        rp_s;
    logic        rm_s;
    logic        vx_s;
    logic        vy_s;

    qrs_div #(.NUM_W(NW), .DEN_W(DENW)) u_div_plus (
        .i_clk(i_clk), .i_en(en), .i_num(r3_nump), .i_den(r3_den2),
        .o_quot(rp_q), .o_sat(rp_s)
    );
    qrs_div #(.NUM_W(NW), .DEN_W(DENW)) u_div_minus (
        .i_clk(i_clk), .i_en(en), .i_num(r3_numm), .i_den(r3_den2),
        .o_quot(rm_q), .o_sat(rm_s)
    );
    qrs_div #(.NUM_W(NW), .DEN_W(DENW)) u_div_vx (
        .i_clk(i_clk), .i_en(en), .i_num(r3_numx), .i_den(r3_den2),
        .o_quot(vx_q), .o_sat(vx_s)
    );
    qrs_div #(.NUM_W(NW), .DEN_W(DENW)) u_div_vy (
        .i_clk(i_clk), .i_en(en), .i_num(r3_numy), .i_den(r3_den4),
        .o_quot(vy_q), .o_sat(vy_s)
    );

    logic             r_dv  [DIV_LAT];
    qrs_pkg::t_status r_dst [DIV_LAT];

    qrs_pkg::t_status n_ost;
    logic             n_ozero;
    logic             n_onone;
    assign n_ost   = r_dst[DIV_LAT-1];
    assign n_ozero = (n_ost == qrs_pkg::ST_ZERO);
    assign n_onone = (n_ost == qrs_pkg::ST_NONE);

    logic             r_ovld;
    qrs_pkg::t_status r_ost;
    logic [31:0]      r_orp;
    logic [31:0]      r_orm;
    logic [31:0]      r_ovx;
    logic [31:0]      r_ovy;
    logic             r_osat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
            r2_vld <= 1'b0;
            r3_vld <= 1'b0;
            r_ovld <= 1'b0;
            for (int j = 0; j < SQ_LAT; j++) begin
                r_sv[j] <= 1'b0;
            end
            for (int j = 0; j < DIV_LAT; j++) begin
                r_dv[j] <= 1'b0;
            end
        end else if (en) begin
            r1_vld  <= i_valid;
            r2_vld  <= r1_vld;
            r_sv[0] <= r2_vld;
            for (int j = 1; j < SQ_LAT; j++) begin
                r_sv[j] <= r_sv[j-1];
            end
            r3_vld  <= r_sv[SQ_LAT-1];
            r_dv[0] <= r3_vld;
            for (int j = 1; j < DIV_LAT; j++) begin
                r_dv[j] <= r_dv[j-1];
            end
            r_ovld <= r_dv[DIV_LAT-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_a  <= i_coef_a;
            r1_b  <= i_coef_b;
            r1_bb <= n1_bb;
            r1_ac <= n1_ac;

            r2_d      <= n2_d;
            r2_nb     <= n2_nb;
            r2_a      <= r1_a;
            r2_status <= n2_status;

            r_sst[0] <= r2_status;
            r_snb[0] <= r2_nb;
            r_sd[0]  <= r2_d;
            r_sa[0]  <= r2_a;
            for (int j = 1; j < SQ_LAT; j++) begin
                r_sst[j] <= r_sst[j-1];
                r_snb[j] <= r_snb[j-1];
                r_sd[j]  <= r_sd[j-1];
                r_sa[j]  <= r_sa[j-1];
            end

            r3_status <= r_sst[SQ_LAT-1];
            r3_nump   <= NW'(r_snb[SQ_LAT-1]) + n3_s;
            r3_numm   <= NW'(r_snb[SQ_LAT-1]) - n3_s;
            r3_numx   <= NW'(r_snb[SQ_LAT-1]);
            r3_numy   <= (-NW'(r_sd[SQ_LAT-1])) <<< YSH;
            r3_den2   <= DENW'(r_sa[SQ_LAT-1]) <<< 1;
            r3_den4   <= DENW'(r_sa[SQ_LAT-1]) <<< 2;

            r_dst[0] <= r3_status;
            for (int j = 1; j < DIV_LAT; j++) begin
                r_dst[j] <= r_dst[j-1];
            end

            r_ost  <= n_ost;
            r_orp  <= (n_ozero || n_onone) ? 32'd0 : rp_q;
            r_orm  <= (n_ozero || n_onone) ? 32'd0 : rm_q;
            r_ovx  <= n_ozero ? 32'd0 : vx_q;
            r_ovy  <= n_ozero ? 32'd0 : vy_q;
            r_osat <= !n_ozero && ((!n_onone && (rp_s || rm_s)) || vx_s || vy_s);
        end
    end

    assign o_valid       = r_ovld;
    assign o_root_status = r_ost;
    assign o_root_plus   = r_orp;
    assign o_root_minus  = r_orm;
    assign o_vertex_x    = r_ovx;
    assign o_vertex_y    = r_ovy;
    assign o_saturated   = r_osat;

    `QRS_ASSERT_IMPL(a_zero_outputs, i_clk, i_rst_n, o_valid && (r_ost == qrs_pkg::ST_ZERO), o_root_plus == 32'sd0 && o_root_minus == 32'sd0 && o_vertex_x == 32'sd0 && o_vertex_y == 32'sd0 && !o_saturated)
    `QRS_ASSERT_IMPL(a_none_roots, i_clk, i_rst_n, o_valid && (r_ost == qrs_pkg::ST_NONE), o_root_plus == 32'sd0 && o_root_minus == 32'sd0)
    `QRS_ASSERT_IMPL(a_double_root, i_clk, i_rst_n, o_valid && (r_ost == qrs_pkg::ST_ONE), o_root_plus == o_root_minus)
    `QRS_ASSERT_IMPL(a_ready_empty, i_clk, i_rst_n, !o_valid, o_ready)
    `QRS_ASSERT_NEXT(a_stall_hold, i_clk, i_rst_n, o_valid && !i_ready, o_valid && $stable(o_vertex_y))
endmodule

[verif/quadratic_root_solver_tb.sv]
// Self-checking testbench of the quadratic root solver with a bit-exact predictor.
module quadratic_root_solver_tb;
    typedef struct packed {
        logic [1:0]   status;
        logic [31:0]  rplus;
        logic [31:0]  rminus;
        logic [31:0]  vx;
        logic [31:0]  vy;
        logic         sat;
    } t_solution;

    typedef struct {
        logic signed [15:0] a;
        logic signed [15:0] b;
        logic signed [15:0] c;
        bit                 fixed;
        t_solution          sol;
    } t_row;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_valid = 1'b0;
    logic               o_ready;
    logic signed [15:0] i_coef_a = '0;
    logic signed [15:0] i_coef_b = '0;
    logic signed [15:0] i_coef_c = '0;
    logic               o_valid;
    logic               i_ready = 1'b0;
    logic [1:0]         o_root_status;
    logic signed [31:0] o_root_plus;
    logic signed [31:0] o_root_minus;
    logic signed [31:0] o_vertex_x;
    logic signed [31:0] o_vertex_y;
    logic               o_saturated;

    t_solution pending_solutions[$];
    int        mismatch_count = 0;
    int        send_idle_pct = 15;
    int        recv_idle_pct = 70;
    bit        hold_start = 1'b0;
    bit        hold_active = 1'b0;

    quadratic_root_solver u_top (.*);

    always #1 i_clk = ~i_clk;

    function automatic logic [63:0] isqrt_scaled(input logic [63:0] d);
        logic [127:0] rem;
        logic [127:0] root;
        logic [127:0] trial;
        logic [1:0]   pair;
        rem = '0;
        root = '0;
        for (int i = 0; i < 48; i++) begin
            pair = (i < 32) ? d[63-2*i -: 2] : 2'b00;
            rem = (rem << 2) | pair;
            root = root << 1;
            trial = (root << 1) | 1;
            if (rem >= trial) begin
                rem = rem - trial;
                root = root | 1;
            end
        end
        return root[63:0];
    endfunction

    function automatic longint round_div(input longint num, input longint den);
        longint un;
        longint ud;
        longint q;
        un = (num < 0) ? -num : num;
        ud = (den < 0) ? -den : den;
        q = (un + ud / 2) / ud;
        return ((num < 0) != (den < 0)) ? -q : q;
    endfunction

    function automatic logic [31:0] clip_q16(input longint v, inout logic flag);
        if (v > 64'sd2147483647) begin
            flag = 1'b1;
            return 32'h7fff_ffff;
        end
        if (v < -64'sd2147483648) begin
            flag = 1'b1;
            return 32'h8000_0000;
        end
        return v[31:0];
    endfunction

    function automatic t_solution solve_quadratic(input logic signed [15:0] a,
                                                  input logic signed [15:0] b,
                                                  input logic signed [15:0] c);
        t_solution s;
        longint    la;
        longint    lb;
        longint    lc;
        longint    disc;
        longint    nb;
        longint    sq;
        logic      f;
        s = '0;
        f = 1'b0;
        la = a;
        lb = b;
        lc = c;
        if (la == 0) begin
            s.status = qrs_pkg::ST_ZERO;
            return s;
        end
        disc = lb * lb - 4 * la * lc;
        nb = -lb * (64'sd1 <<< qrs_pkg::OUT_FRAC);
        s.status = (disc > 0) ? qrs_pkg::ST_TWO :
                   (disc == 0) ? qrs_pkg::ST_ONE : qrs_pkg::ST_NONE;
        if (disc >= 0) begin
            sq = isqrt_scaled(disc);
            s.rplus = clip_q16(round_div(nb + sq, 2 * la), f);
            s.rminus = clip_q16(round_div(nb - sq, 2 * la), f);
        end
        s.vx = clip_q16(round_div(nb, 2 * la), f);
        s.vy = clip_q16(round_div(-disc * (64'sd1 <<< (qrs_pkg::OUT_FRAC - 8)), 4 * la), f);
        s.sat = f;
        return s;
    endfunction

    task automatic send_equation(input logic signed [15:0] a, input logic signed [15:0] b,
                                 input logic signed [15:0] c, input t_solution sol);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_coef_a <= a;
        i_coef_b <= b;
        i_coef_c <= c;
        do @(posedge i_clk); while (!o_ready);
        pending_solutions.push_back(sol);
    endtask

    always @(posedge i_clk) begin
        t_solution got;
        t_solution want;
        if (i_rst_n && o_valid && i_ready) begin
            got = '{o_root_status, o_root_plus, o_root_minus, o_vertex_x, o_vertex_y,
                    o_saturated};
            if (pending_solutions.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10) $display("Unexpected transaction %h", got);
            end else begin
                want = pending_solutions.pop_front();
                if (got !== want) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("Mismatch: expected %h, actual %h", want, got);
                end
            end
        end
        if (hold_active) begin
            i_ready <= 1'b0;
        end else begin
            i_ready <= i_rst_n && ($urandom_range(99) >= recv_idle_pct);
        end
    end

    initial begin
        wait (hold_start);
        @(posedge i_clk);
        hold_active <= 1'b1;
        repeat (400) @(posedge i_clk);
        hold_active <= 1'b0;
    end

    initial begin
        t_row               rows[$];
        t_solution          sol;
        logic signed [15:0] a;
        logic signed [15:0] b;
        logic signed [15:0] c;
        int                 wait_cycles;
        rows.push_back('{16'sd0, 16'sd5, 16'sd7, 1'b1,
                         '{qrs_pkg::ST_ZERO, 0, 0, 0, 0, 1'b0}});
        rows.push_back('{16'sd0, -16'sd32768, 16'sd32767, 1'b1,
                         '{qrs_pkg::ST_ZERO, 0, 0, 0, 0, 1'b0}});
        rows.push_back('{16'sd256, 16'sd0, 16'sd0, 1'b1,
                         '{qrs_pkg::ST_ONE, 0, 0, 0, 0, 1'b0}});
        rows.push_back('{16'sd256, 16'sd0, -16'sd256, 1'b0, '0});
        rows.push_back('{16'sd256, 16'sd0, 16'sd256, 1'b0, '0});
        rows.push_back('{16'sd256, -16'sd512, 16'sd256, 1'b0, '0});
        rows.push_back('{16'sd1, -16'sd32768, 16'sd0, 1'b0, '0});
        rows.push_back('{16'sd1, 16'sd32767, -16'sd32768, 1'b0, '0});
        rows.push_back('{-16'sd32768, -16'sd32768, -16'sd32768, 1'b0, '0});
        rows.push_back('{16'sd32767, 16'sd32767, 16'sd32767, 1'b0, '0});
        rows.push_back('{-16'sd32768, 16'sd32767, 16'sd32767, 1'b0, '0});
        rows.push_back('{16'sd32767, -16'sd32768, -16'sd32768, 1'b0, '0});
        rows.push_back('{-16'sd1, 16'sd0, 16'sd1, 1'b0, '0});
        rows.push_back('{16'sd1, 16'sd2, 16'sd1, 1'b0, '0});
        rows.push_back('{-16'sd256, 16'sd768, -16'sd512, 1'b0, '0});
        rows.push_back('{16'sd3, 16'sd1, -16'sd1, 1'b0, '0});

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (rows[i]) begin
            sol = rows[i].fixed ? rows[i].sol : solve_quadratic(rows[i].a, rows[i].b, rows[i].c);
            send_equation(rows[i].a, rows[i].b, rows[i].c, sol);
        end
        for (int n = 0; n < 1150; n++) begin
            if (n == 380) begin
                send_idle_pct = 70;
                recv_idle_pct = 15;
            end
            if (n == 760) begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
                hold_start = 1'b1;
            end
            a = $urandom;
            b = $urandom;
            c = $urandom;
            case ($urandom_range(7))
                0: a = '0;
                1: begin a = $urandom_range(255) - 128; b = $urandom_range(2047) - 1024; end
                2: c = $urandom_range(7) - 4;
                3: b = (a[0]) ? -16'sd32768 : 16'sd32767;
                default: ;
            endcase
            send_equation(a, b, c, solve_quadratic(a, b, c));
        end
        i_valid <= 1'b0;
        wait_cycles = 0;
        while (pending_solutions.size() != 0 && wait_cycles < 100000) begin
            @(posedge i_clk);
            wait_cycles++;
        end
        repeat (200) @(posedge i_clk);
        if (mismatch_count == 0 && pending_solutions.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    initial begin
        #400000;
        $display("[FAIL] regression broken");
        $finish;
    end
endmodule
